// File: design/binary_min_heap_queue_assert.svh
// Assertion macros for the binary min-heap queue.
// Expects clk and rst_n (synchronous, active low) in the scope of each use.
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// Same-cycle implication
`define BMHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
// Used by bmhq_ctrl, bmhq_dp and binary_min_heap_queue; no dependencies.
package bmhq_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int KEY_WIDTH    = 16;
  localparam int ID_WIDTH     = 16;
  localparam int ACTION_WIDTH = 2;
  localparam int STATUS_WIDTH = 2;
  localparam int COUNT_WIDTH  = 9;

  localparam logic [ACTION_WIDTH-1:0] ACT_APPEND  = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_BUILD   = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_INSERT  = 2'd2;
  localparam logic [ACTION_WIDTH-1:0] ACT_EXTRACT = 2'd3;

  localparam logic [STATUS_WIDTH-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0] action;
    logic [KEY_WIDTH-1:0]    key;
    logic [ID_WIDTH-1:0]     entry_id;
  } in_item_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]    out_key;
    logic [ID_WIDTH-1:0]     out_id;
    logic                    out_valid;
    logic [STATUS_WIDTH-1:0] status;
    logic [COUNT_WIDTH-1:0]  count_now;
  } out_item_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [ID_WIDTH-1:0]  id;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;       // latch input item, clear result
    logic wr_append;    // write item at end, count up
    logic up_start;     // moving entry = item, pos = count, count up
    logic rd_parent;    // read parent of pos
    logic up_step;      // parent down into pos, pos = parent
    logic wr_mv;        // moving entry into pos
    logic rd_children;  // read both children of pos
    logic dn_step;      // smaller child up into pos, pos = child
    logic bld_start;    // build index = count / 2
    logic bld_rd;       // read entry at build index - 1
    logic bld_ld;       // moving entry from read, pos = index - 1
    logic ex_rd;        // read root and last, count down
    logic ex_ld;        // result = root, moving entry = last, pos = 0
    logic err_empty;
    logic err_full;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACTION_WIDTH-1:0] act;
    logic full;
    logic empty;
    logic pos_zero;
    logic leaf;
    logic up_swap;
    logic dn_move;
    logic bi_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: design/bmhq_ctrl.sv
// Sequencer for the binary min-heap queue: steps appends, sifts, builds
// and extracts. Depends on bmhq_pkg and binary_min_heap_queue_assert.svh.
`include "binary_min_heap_queue_assert.svh"

module bmhq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bmhq_pkg::ctrl_sts_t  sts,
  output bmhq_pkg::ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_UP      = 4'd2;
  localparam logic [3:0] S_UP_WAIT = 4'd3;
  localparam logic [3:0] S_BLD     = 4'd4;
  localparam logic [3:0] S_BLD_LD  = 4'd5;
  localparam logic [3:0] S_DN      = 4'd6;
  localparam logic [3:0] S_DN_WAIT = 4'd7;
  localparam logic [3:0] S_EX_LD   = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       is_build;

  assign in_stall = (state_r != S_IDLE);
  assign is_build = (sts.act == bmhq_pkg::ACT_BUILD);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.act)
          bmhq_pkg::ACT_APPEND: begin
            if (sts.full) cmd.err_full = 1'b1;
            else          cmd.wr_append = 1'b1;
            state_nxt = S_FIN;
          end
          bmhq_pkg::ACT_INSERT: begin
            if (sts.full) begin
              cmd.err_full = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              cmd.up_start = 1'b1;
              state_nxt    = S_UP;
            end
          end
          bmhq_pkg::ACT_BUILD: begin
            cmd.bld_start = 1'b1;
            state_nxt     = S_BLD;
          end
          bmhq_pkg::ACT_EXTRACT: begin
            if (sts.empty) begin
              cmd.err_empty = 1'b1;
              state_nxt     = S_FIN;
            end else begin
              cmd.ex_rd = 1'b1;
              state_nxt = S_EX_LD;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_UP: begin
        if (sts.pos_zero) begin
          cmd.wr_mv = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_WAIT;
        end
      end
      S_UP_WAIT: begin
        if (sts.up_swap) begin
          cmd.up_step = 1'b1;
          state_nxt   = S_UP;
        end else begin
          cmd.wr_mv = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_BLD: begin
        if (sts.bi_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.bld_rd = 1'b1;
          state_nxt  = S_BLD_LD;
        end
      end
      S_BLD_LD: begin
        cmd.bld_ld = 1'b1;
        state_nxt  = S_DN;
      end
      S_EX_LD: begin
        cmd.ex_ld = 1'b1;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (sts.leaf) begin
          cmd.wr_mv = 1'b1;
          state_nxt = is_build ? S_BLD : S_FIN;
        end else begin
          cmd.rd_children = 1'b1;
          state_nxt       = S_DN_WAIT;
        end
      end
      S_DN_WAIT: begin
        if (sts.dn_move) begin
          cmd.dn_step = 1'b1;
          state_nxt   = S_DN;
        end else begin
          cmd.wr_mv = 1'b1;
          state_nxt = is_build ? S_BLD : S_FIN;
        end
      end
      S_FIN: begin
        // hold the result until the output register has room
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `BMHQ_ASSERT_NEXT(a_accept_disp, in_valid && !in_stall, state_r == S_DISP, "accept did not dispatch")
  `BMHQ_ASSERT_NOW(a_one_writer, 1'b1, $onehot0({cmd.wr_append, cmd.up_step, cmd.wr_mv, cmd.dn_step}), "two memory writes in one cycle")
  `BMHQ_ASSERT_NOW(a_load_free, cmd.out_load, sts.out_free, "result loaded over a waiting item")

endmodule

// File: design/bmhq_dp.sv
// Datapath for the binary min-heap queue: entry memory, count, sift
// position, moving entry and result registers. Depends on bmhq_pkg.
`include "binary_min_heap_queue_assert.svh"

module bmhq_dp #(
  parameter int DEPTH = bmhq_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bmhq_pkg::in_item_t   in_data,
  input  bmhq_pkg::ctrl_cmd_t  cmd,
  output bmhq_pkg::ctrl_sts_t  sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bmhq_pkg::out_item_t  out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  bmhq_pkg::entry_t mem [DEPTH];

  bmhq_pkg::in_item_t item_r;
  bmhq_pkg::entry_t   mv_r, rda_r, rdb_r;
  bmhq_pkg::entry_t   item_ent, child, wd;
  bmhq_pkg::out_item_t out_r;

  logic [CW-1:0] cnt_r, bi_r;
  logic [AW-1:0] pos_r, parent, child_idx, ra, rb, wa;
  logic [XW-1:0] left_w, right_w, cnt_x;
  logic          we, l_lt, r_lt, right_in, ovalid_r;
  logic [bmhq_pkg::KEY_WIDTH-1:0]    best_key;
  logic [bmhq_pkg::KEY_WIDTH-1:0]    res_key_r;
  logic [bmhq_pkg::ID_WIDTH-1:0]     res_id_r;
  logic                              res_vld_r;
  logic [bmhq_pkg::STATUS_WIDTH-1:0] res_stat_r;

  assign item_ent = '{key: item_r.key, id: item_r.entry_id};

  assign left_w   = {1'b0, pos_r, 1'b1};
  assign right_w  = left_w + XW'(1);
  assign cnt_x    = XW'(cnt_r);
  assign right_in = (right_w < cnt_x);
  assign parent   = (pos_r - AW'(1)) >> 1;

  // left is always in range once the node is known not to be a leaf
  assign l_lt      = (rda_r.key < mv_r.key);
  assign best_key  = l_lt ? rda_r.key : mv_r.key;
  assign r_lt      = right_in && (rdb_r.key < best_key);
  assign child     = r_lt ? rdb_r : rda_r;
  assign child_idx = r_lt ? AW'(right_w) : AW'(left_w);

  always_comb begin
    sts          = '0;
    sts.act      = item_r.action;
    sts.full     = (cnt_r == DEPTH_C);
    sts.empty    = (cnt_r == '0);
    sts.pos_zero = (pos_r == '0);
    sts.leaf     = (left_w >= cnt_x);
    sts.up_swap  = (rda_r.key > mv_r.key);
    sts.dn_move  = l_lt || r_lt;
    sts.bi_zero  = (bi_r == '0);
    sts.out_free = !ovalid_r || !out_stall;
  end

  // read and write addresses
  always_comb begin
    priority if (cmd.ex_rd)       ra = '0;
    else if     (cmd.rd_children) ra = AW'(left_w);
    else if     (cmd.bld_rd)      ra = AW'(bi_r - CW'(1));
    else if     (cmd.rd_parent)   ra = parent;
    else                          ra = '0;
    rb = cmd.rd_children ? AW'(right_w) : AW'(cnt_r - CW'(1));
    we = cmd.wr_append || cmd.up_step || cmd.wr_mv || cmd.dn_step;
    wa = cmd.wr_append ? AW'(cnt_r) : pos_r;
    priority if (cmd.wr_append) wd = item_ent;
    else if     (cmd.up_step)   wd = rda_r;
    else if     (cmd.dn_step)   wd = child;
    else                        wd = mv_r;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rda_r <= mem[ra];
    rdb_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.wr_append || cmd.up_start) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.ex_rd) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) item_r <= in_data;

    if (cmd.up_start)     pos_r <= AW'(cnt_r);
    else if (cmd.up_step) pos_r <= parent;
    else if (cmd.dn_step) pos_r <= child_idx;
    else if (cmd.bld_ld)  pos_r <= AW'(bi_r - CW'(1));
    else if (cmd.ex_ld)   pos_r <= '0;

    if (cmd.up_start)    mv_r <= item_ent;
    else if (cmd.bld_ld) mv_r <= rda_r;
    else if (cmd.ex_ld)  mv_r <= rdb_r;

    if (cmd.bld_start)   bi_r <= cnt_r >> 1;
    else if (cmd.bld_ld) bi_r <= bi_r - CW'(1);

    if (cmd.accept) begin
      res_key_r  <= '0;
      res_id_r   <= '0;
      res_vld_r  <= 1'b0;
      res_stat_r <= bmhq_pkg::STAT_OK;
    end else if (cmd.err_empty) begin
      res_stat_r <= bmhq_pkg::STAT_EMPTY;
    end else if (cmd.err_full) begin
      res_stat_r <= bmhq_pkg::STAT_FULL;
    end else if (cmd.ex_ld) begin
      res_key_r <= rda_r.key;
      res_id_r  <= rda_r.id;
      res_vld_r <= 1'b1;
    end

    if (cmd.out_load) begin
      out_r.out_key   <= res_key_r;
      out_r.out_id    <= res_id_r;
      out_r.out_valid <= res_vld_r;
      out_r.status    <= res_stat_r;
      out_r.count_now <= bmhq_pkg::COUNT_WIDTH'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            ovalid_r <= 1'b0;
    else if (cmd.out_load) ovalid_r <= 1'b1;
    else if (!out_stall)   ovalid_r <= 1'b0;
  end

  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  `BMHQ_ASSERT_NOW(a_cnt_max, 1'b1, cnt_r <= DEPTH_C, "entry count above depth")
  `BMHQ_ASSERT_NOW(a_no_overfill, cmd.wr_append || cmd.up_start, cnt_r < DEPTH_C, "write past the last entry")
  `BMHQ_ASSERT_NOW(a_vld_ok, ovalid_r && out_r.out_valid, out_r.status == bmhq_pkg::STAT_OK, "extracted item flagged as error")

endmodule

// File: design/binary_min_heap_queue.sv
// Binary min-heap of (key, id) entries in a DEPTH-entry memory with two
// registered read ports and one write port; one item is worked at a time.
// An insert rises level by level toward the root; an extract moves the
// last entry to the root and sinks it level by level (at most log2(DEPTH)
// levels). Each level costs one memory read and one write, which sets the
// pace. A build sinks each of the count/2 inner nodes in turn, last first,
// and holds off input while it runs. A finished result waits in an output
// register; the next item may be taken meanwhile.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_dp.

module binary_min_heap_queue #(
  parameter int DEPTH = bmhq_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmhq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmhq_pkg::out_item_t out_data
);

  bmhq_pkg::ctrl_cmd_t cmd;
  bmhq_pkg::ctrl_sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmhq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/binary_min_heap_queue_tb.sv
// Self-checking testbench for binary_min_heap_queue: directed rows, then random
// grow and shrink phases, checked against typed results or an in-bench heap model.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL only.
module binary_min_heap_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bmhq_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  bmhq_pkg::out_item_t out_data;

  binary_min_heap_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  typedef struct {
    bmhq_pkg::in_item_t  item;
    bit                  typed;
    bmhq_pkg::out_item_t res;
  } stim_row_t;

  stim_row_t           directed_rows[$];
  bmhq_pkg::out_item_t pending_results[$];
  int unsigned         fails = 0;
  bit                  calm = 1'b0;
  bit                  hold_req = 1'b0;

  // Heap mirror
  logic [bmhq_pkg::KEY_WIDTH-1:0] heap_key [bmhq_pkg::DEPTH_DEF];
  logic [bmhq_pkg::ID_WIDTH-1:0]  heap_id  [bmhq_pkg::DEPTH_DEF];
  int unsigned                    heap_n = 0;

  function automatic void heap_swap(int unsigned a, int unsigned b);
    logic [bmhq_pkg::KEY_WIDTH-1:0] k;
    logic [bmhq_pkg::ID_WIDTH-1:0]  d;
    k = heap_key[a]; heap_key[a] = heap_key[b]; heap_key[b] = k;
    d = heap_id[a];  heap_id[a]  = heap_id[b];  heap_id[b]  = d;
  endfunction

  function automatic void heap_sift_down(int unsigned pos, int unsigned n);
    int unsigned left, right, best;
    forever begin
      left  = 2 * pos + 1;
      right = 2 * pos + 2;
      best  = pos;
      if (left < n && heap_key[left] < heap_key[pos]) best = left;
      if (right < n && heap_key[right] < heap_key[best]) best = right;
      if (best == pos) return;
      heap_swap(pos, best);
      pos = best;
    end
  endfunction

  function automatic void heap_sift_up(int unsigned pos);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) >> 1;
      if (!(heap_key[parent] > heap_key[pos])) return;
      heap_swap(parent, pos);
      pos = parent;
    end
  endfunction

  // Applies one item to the mirror and returns the result it should give
  function automatic bmhq_pkg::out_item_t heap_apply(bmhq_pkg::in_item_t it);
    bmhq_pkg::out_item_t res;
    res = '0;
    res.status = bmhq_pkg::STAT_OK;
    case (it.action)
      bmhq_pkg::ACT_APPEND, bmhq_pkg::ACT_INSERT: begin
        if (heap_n >= bmhq_pkg::DEPTH_DEF) begin
          res.status = bmhq_pkg::STAT_FULL;
        end else begin
          heap_key[heap_n] = it.key;
          heap_id[heap_n]  = it.entry_id;
          if (it.action == bmhq_pkg::ACT_INSERT) heap_sift_up(heap_n);
          heap_n++;
        end
      end
      bmhq_pkg::ACT_BUILD: begin
        for (int unsigned i = heap_n / 2; i > 0; i--) heap_sift_down(i - 1, heap_n);
      end
      default: begin
        if (heap_n == 0) begin
          res.status = bmhq_pkg::STAT_EMPTY;
        end else begin
          res.out_key   = heap_key[0];
          res.out_id    = heap_id[0];
          res.out_valid = 1'b1;
          heap_n--;
          heap_key[0] = heap_key[heap_n];
          heap_id[0]  = heap_id[heap_n];
          heap_sift_down(0, heap_n);
        end
      end
    endcase
    res.count_now = bmhq_pkg::COUNT_WIDTH'(heap_n);
    return res;
  endfunction

  function automatic bmhq_pkg::in_item_t random_item(bit growing);
    bmhq_pkg::in_item_t it;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (growing)
      it.action = pick < 30 ? bmhq_pkg::ACT_APPEND : pick < 85 ? bmhq_pkg::ACT_INSERT :
                  pick < 95 ? bmhq_pkg::ACT_EXTRACT : bmhq_pkg::ACT_BUILD;
    else
      it.action = pick < 70 ? bmhq_pkg::ACT_EXTRACT : pick < 85 ? bmhq_pkg::ACT_INSERT :
                  pick < 95 ? bmhq_pkg::ACT_APPEND : bmhq_pkg::ACT_BUILD;
    // narrow keys now and then so that ties are common
    it.key      = ($urandom_range(0, 3) == 0) ?
                  bmhq_pkg::KEY_WIDTH'($urandom_range(0, 15)) :
                  bmhq_pkg::KEY_WIDTH'($urandom);
    it.entry_id = bmhq_pkg::ID_WIDTH'($urandom);
    return it;
  endfunction

  task automatic add_row(input logic [bmhq_pkg::ACTION_WIDTH-1:0] act,
                         input logic [15:0] key, input logic [15:0] id, input bit typed,
                         input logic [15:0] okey, input logic [15:0] oid,
                         input logic ov, input logic [bmhq_pkg::STATUS_WIDTH-1:0] st,
                         input logic [bmhq_pkg::COUNT_WIDTH-1:0] cnt);
    stim_row_t r;
    r.item  = '{action: act, key: key, entry_id: id};
    r.typed = typed;
    r.res   = '{out_key: okey, out_id: oid, out_valid: ov, status: st, count_now: cnt};
    directed_rows.push_back(r);
  endtask

  task automatic send_item(input bmhq_pkg::in_item_t it, input bit typed,
                           input bmhq_pkg::out_item_t typed_res);
    bmhq_pkg::out_item_t res;
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = heap_apply(it);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic flag_mismatch(input string name, input logic [31:0] e, input logic [31:0] a);
    $error("%s mismatch: expected %0h, got %0h", name, e, a);
  endtask

  // Result checker
  always @(posedge clk) begin
    bmhq_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %p", out_data);
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (out_data !== e) begin
          fails++;
          if (out_data.out_key !== e.out_key)
            flag_mismatch("out_key", 32'(e.out_key), 32'(out_data.out_key));
          if (out_data.out_id !== e.out_id)
            flag_mismatch("out_id", 32'(e.out_id), 32'(out_data.out_id));
          if (out_data.out_valid !== e.out_valid)
            flag_mismatch("out_valid", 32'(e.out_valid), 32'(out_data.out_valid));
          if (out_data.status !== e.status)
            flag_mismatch("status", 32'(e.status), 32'(out_data.status));
          if (out_data.count_now !== e.count_now)
            flag_mismatch("count_now", 32'(e.count_now), 32'(out_data.count_now));
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, calm stretch on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 37);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned guard;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // empty and small-heap cases, extreme keys and ids
    add_row(bmhq_pkg::ACT_EXTRACT, 16'h0000, 16'h0000, 1'b1,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_EMPTY, 9'd0);
    add_row(bmhq_pkg::ACT_BUILD,   16'hffff, 16'hffff, 1'b1,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd0);
    add_row(bmhq_pkg::ACT_INSERT,  16'hffff, 16'hffff, 1'b1,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd1);
    add_row(bmhq_pkg::ACT_BUILD,   16'h0000, 16'h0000, 1'b1,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd1);
    add_row(bmhq_pkg::ACT_INSERT,  16'h0000, 16'h0000, 1'b1,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd2);
    add_row(bmhq_pkg::ACT_APPEND,  16'h8000, 16'h0001, 1'b1,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd3);
    add_row(bmhq_pkg::ACT_EXTRACT, 16'h0000, 16'h0000, 1'b1,
            16'h0000, 16'h0000, 1'b1, bmhq_pkg::STAT_OK, 9'd2);
    add_row(bmhq_pkg::ACT_EXTRACT, 16'h0000, 16'h0000, 1'b1,
            16'h8000, 16'h0001, 1'b1, bmhq_pkg::STAT_OK, 9'd1);
    add_row(bmhq_pkg::ACT_EXTRACT, 16'h0000, 16'h0000, 1'b1,
            16'hffff, 16'hffff, 1'b1, bmhq_pkg::STAT_OK, 9'd0);
    add_row(bmhq_pkg::ACT_EXTRACT, 16'hffff, 16'hffff, 1'b1,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_EMPTY, 9'd0);
    // unordered appends with equal keys, then build, tie insert and drain
    add_row(bmhq_pkg::ACT_APPEND,  16'h7fff, 16'h0a0a, 1'b0,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd0);
    add_row(bmhq_pkg::ACT_APPEND,  16'h0001, 16'h5555, 1'b0,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd0);
    add_row(bmhq_pkg::ACT_APPEND,  16'h0001, 16'haaaa, 1'b0,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd0);
    add_row(bmhq_pkg::ACT_APPEND,  16'h1234, 16'h00ff, 1'b0,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd0);
    add_row(bmhq_pkg::ACT_APPEND,  16'h0000, 16'hff00, 1'b0,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd0);
    add_row(bmhq_pkg::ACT_BUILD,   16'h5a5a, 16'ha5a5, 1'b0,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd0);
    add_row(bmhq_pkg::ACT_INSERT,  16'h0001, 16'h0f0f, 1'b0,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd0);
    repeat (6)
      add_row(bmhq_pkg::ACT_EXTRACT, 16'h0000, 16'h0000, 1'b0,
              16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_OK, 9'd0);
    add_row(bmhq_pkg::ACT_EXTRACT, 16'h0000, 16'h0000, 1'b1,
            16'h0000, 16'h0000, 1'b0, bmhq_pkg::STAT_EMPTY, 9'd0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);

    // receiver holds off as the heap starts to grow, so input backs up
    hold_req = 1'b1;
    while (heap_n < bmhq_pkg::DEPTH_DEF) send_item(random_item(1'b1), 1'b0, '0);
    repeat (8) send_item(random_item(1'b1), 1'b0, '0);  // mostly full-heap attempts

    calm = 1'b1;
    repeat (40) send_item(random_item(1'b0), 1'b0, '0);
    calm = 1'b0;
    repeat (40) send_item(random_item(1'b0), 1'b0, '0);
    in_valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      fails++;
    end
    repeat (40) @(posedge clk);
    if (fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/bmhq_pkg.sv
design/bmhq_ctrl.sv
design/bmhq_dp.sv
design/binary_min_heap_queue.sv
tb/sv/binary_min_heap_queue_tb.sv
